### src/cds_pkg.sv
// cds_pkg: shared types, constants and calendar helper functions
// for the calendar date stepper; no dependencies
package cds_pkg;

  localparam int OP_W    = 3;
  localparam int CNT_W   = 10;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;
  localparam int WOY_W   = 6;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_28    = 5'd28;
  localparam logic [DAY_W-1:0] DAY_29    = 5'd29;
  localparam logic [DAY_W-1:0] DAY_30    = 5'd30;
  localparam logic [DAY_W-1:0] DAY_31    = 5'd31;

  // modular inverse of 25 mod 2**14 and the largest quotient of a multiple of 25
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

  // reciprocal of 7 scaled by 2**14, exact for day counts below 366
  localparam logic [11:0] RECIP7 = 12'd2341;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 3'd0,
    OP_DAY_INC  = 3'd1,
    OP_DAY_DEC  = 3'd2,
    OP_MON_INC  = 3'd3,
    OP_MON_DEC  = 3'd4,
    OP_YEAR_INC = 3'd5,
    OP_YEAR_DEC = 3'd6,
    OP_QUERY    = 3'd7
  } op_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t date;
    logic  err;
    logic  year_chg;
  } step_res_t;

  typedef struct packed {
    logic              date_valid;
    logic [DOY_W-1:0]  doy;
    logic [WOY_W-1:0]  woy;
  } report_t;

  function automatic logic is_leap(logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = y * INV25;
    div25 = prod[YEAR_W-1:0] <= DIV25_MAX;
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic leap, logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                                  len = leap ? DAY_29 : DAY_28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_31;
      default:                               len = DAY_30;
    endcase
    return len;
  endfunction

  // days before the first of month m, leap day included after february
  function automatic logic [DOY_W-1:0] days_before(logic leap, logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] base;
    case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (m > MON_FEB)) ? 9'd1 : 9'd0);
  endfunction

endpackage

### src/cds_step_unit.sv
// cds_step_unit: shared single-unit step of a date by one day or one month
// depends on cds_pkg
module cds_step_unit #(
  parameter int YEAR_MAX = 9999
) (
  input  cds_pkg::op_t      op_i,
  input  cds_pkg::date_t    date_i,
  input  logic              leap_i,
  output cds_pkg::step_res_t res_o
);

  logic [cds_pkg::MONTH_W-1:0] m_inc;
  logic [cds_pkg::MONTH_W-1:0] m_dec;
  logic [cds_pkg::DAY_W-1:0]   dim_cur;
  logic [cds_pkg::DAY_W-1:0]   dim_new;
  cds_pkg::date_t              nd;
  logic                        err;
  logic                        chg;

  assign m_inc   = date_i.month + 4'd1;
  assign m_dec   = date_i.month - 4'd1;
  assign dim_cur = cds_pkg::month_len(leap_i, date_i.month);
  assign dim_new = cds_pkg::month_len(leap_i, nd.month);

  always_comb begin
    nd  = date_i;
    err = 1'b0;
    chg = 1'b0;
    case (op_i)
      cds_pkg::OP_DAY_INC: begin
        if (date_i.day >= dim_cur) begin
          nd.day = cds_pkg::DAY_FIRST;
          if (date_i.month >= cds_pkg::MON_DEC) begin
            if (date_i.year >= cds_pkg::YEAR_W'(YEAR_MAX)) begin
              err = 1'b1;
            end else begin
              nd.year  = date_i.year + 14'd1;
              nd.month = cds_pkg::MON_JAN;
              chg      = 1'b1;
            end
          end else begin
            nd.month = m_inc;
          end
        end else begin
          nd.day = date_i.day + 5'd1;
        end
      end
      cds_pkg::OP_DAY_DEC: begin
        if (date_i.day > cds_pkg::DAY_FIRST) begin
          nd.day = date_i.day - 5'd1;
        end else if (date_i.month > cds_pkg::MON_JAN) begin
          nd.month = m_dec;
          nd.day   = cds_pkg::month_len(leap_i, m_dec);
        end else if (date_i.year == '0) begin
          err = 1'b1;
        end else begin
          nd.year  = date_i.year - 14'd1;
          nd.month = cds_pkg::MON_DEC;
          nd.day   = cds_pkg::DAY_31;
          chg      = 1'b1;
        end
      end
      cds_pkg::OP_MON_INC: begin
        if (date_i.month >= cds_pkg::MON_DEC) begin
          if (date_i.year >= cds_pkg::YEAR_W'(YEAR_MAX)) begin
            err = 1'b1;
          end else begin
            nd.year  = date_i.year + 14'd1;
            nd.month = cds_pkg::MON_JAN;
            chg      = 1'b1;
          end
        end else begin
          nd.month = m_inc;
        end
      end
      cds_pkg::OP_MON_DEC: begin
        if (date_i.month > cds_pkg::MON_JAN) begin
          nd.month = m_dec;
        end else if (date_i.year == '0) begin
          err = 1'b1;
        end else begin
          nd.year  = date_i.year - 14'd1;
          nd.month = cds_pkg::MON_DEC;
          chg      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.date     = nd;
    res_o.err      = err;
    res_o.year_chg = chg;
    // month steps clamp the day to the new month length
    if (((op_i == cds_pkg::OP_MON_INC) || (op_i == cds_pkg::OP_MON_DEC)) &&
        (nd.day > dim_new)) begin
      res_o.date.day = dim_new;
    end
  end

endmodule

### src/cds_report_unit.sv
// cds_report_unit: validity, day of year and week of year of a date
// depends on cds_pkg
module cds_report_unit (
  input  cds_pkg::date_t   date_i,
  input  logic             leap_i,
  output cds_pkg::report_t rep_o
);

  logic                       valid;
  logic [cds_pkg::DOY_W-1:0]  doy;
  logic [cds_pkg::DOY_W-1:0]  doy_m1;
  logic [cds_pkg::DOY_W+11:0] prod;

  assign valid = (date_i.month >= cds_pkg::MON_JAN) && (date_i.month <= cds_pkg::MON_DEC) &&
                 (date_i.day >= cds_pkg::DAY_FIRST) &&
                 (date_i.day <= cds_pkg::month_len(leap_i, date_i.month));
  assign doy    = cds_pkg::days_before(leap_i, date_i.month) +
                  cds_pkg::DOY_W'(date_i.day);
  assign doy_m1 = doy - 9'd1;
  // divide by 7 through the scaled reciprocal
  assign prod   = doy_m1 * cds_pkg::RECIP7;

  always_comb begin
    rep_o.date_valid = valid;
    rep_o.doy        = '0;
    rep_o.woy        = '0;
    if (valid) begin
      rep_o.doy = doy;
      rep_o.woy = prod[19:14] + 6'd1;
    end
  end

endmodule

### src/calendar_date_stepper.sv
// calendar_date_stepper: Gregorian date counter top level with its sequencer
// depends on cds_pkg, cds_step_unit and cds_report_unit
//
// Holds one date and applies one transfer at a time. A query or a refused load
// goes straight to ST_REPORT; a load passes ST_LEAP, a year step ST_LEAP and
// ST_YFIX. A day or month step by a count of n applies up to n single steps in
// ST_STEP, passing ST_LEAP at each year boundary crossed, where the leap flag of
// the new year is recomputed: the single step unit moves the date by one day or
// one month a cycle while in ST_STEP. The count saturates at COUNT_MAX, or at
// 1023 if smaller. The input stalls while an item is at work; a finished result
// waits in the output register, and the next item is accepted meanwhile.
module calendar_date_stepper #(
  parameter int YEAR_MAX  = 9999,
  parameter int COUNT_MAX = 1023
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cds_pkg::OP_W-1:0]    in_operation,
  input  logic [cds_pkg::CNT_W-1:0]   in_step_count,
  input  logic [cds_pkg::YEAR_W-1:0]  in_load_year,
  input  logic [cds_pkg::MONTH_W-1:0] in_load_month,
  input  logic [cds_pkg::DAY_W-1:0]   in_load_day,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cds_pkg::YEAR_W-1:0]  out_year_out,
  output logic [cds_pkg::MONTH_W-1:0] out_month_out,
  output logic [cds_pkg::DAY_W-1:0]   out_day_out,
  output logic                        out_leap_year,
  output logic                        out_date_valid,
  output logic [cds_pkg::DOY_W-1:0]   out_day_of_year,
  output logic [cds_pkg::WOY_W-1:0]   out_week_of_year,
  output logic                        out_status
);

  localparam int CntFull = (1 << cds_pkg::CNT_W) - 1;
  localparam int CntCap  = (COUNT_MAX < CntFull) ? COUNT_MAX : CntFull;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_LEAP,
    ST_YFIX,
    ST_REPORT
  } state_t;

  state_t                      state_r, state_nxt;
  cds_pkg::op_t                op_r, op_nxt;
  logic [cds_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  cds_pkg::date_t              wrk_r, wrk_nxt;
  logic                        leap_r, leap_nxt;
  logic                        err_r, err_nxt;
  cds_pkg::date_t              cur_r, cur_nxt;
  logic                        cur_leap_r, cur_leap_nxt;

  logic                        out_valid_r, out_valid_nxt;
  cds_pkg::date_t              out_date_r, out_date_nxt;
  logic                        out_leap_r, out_leap_nxt;
  cds_pkg::report_t            out_rep_r, out_rep_nxt;
  logic                        out_status_r, out_status_nxt;

  logic                        accept;
  logic                        out_free;
  cds_pkg::op_t                in_op;
  logic [cds_pkg::CNT_W-1:0]   cnt_sat;
  logic [cds_pkg::YEAR_W:0]    ysum;
  logic                        yinc_err;
  logic                        ydec_err;
  logic [cds_pkg::YEAR_W-1:0]  ydiff;
  logic                        multi_op;
  cds_pkg::step_res_t          step_res;
  cds_pkg::date_t              rep_date;
  logic                        rep_leap;
  cds_pkg::report_t            rep;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_op    = cds_pkg::op_t'(in_operation);
  assign cnt_sat  = (in_step_count > cds_pkg::CNT_W'(CntCap)) ?
                    cds_pkg::CNT_W'(CntCap) : in_step_count;
  assign ysum     = {1'b0, cur_r.year} + (cds_pkg::YEAR_W + 1)'(cnt_sat);
  assign yinc_err = ysum > (cds_pkg::YEAR_W + 1)'(YEAR_MAX);
  assign ydec_err = cds_pkg::YEAR_W'(cnt_sat) > cur_r.year;
  assign ydiff    = cur_r.year - cds_pkg::YEAR_W'(cnt_sat);
  assign multi_op = (op_r == cds_pkg::OP_DAY_INC) || (op_r == cds_pkg::OP_DAY_DEC) ||
                    (op_r == cds_pkg::OP_MON_INC) || (op_r == cds_pkg::OP_MON_DEC);
  assign rep_date = err_r ? cur_r : wrk_r;
  assign rep_leap = err_r ? cur_leap_r : leap_r;

  cds_step_unit #(
    .YEAR_MAX (YEAR_MAX)
  ) u_step (
    .op_i   (op_r),
    .date_i (wrk_r),
    .leap_i (leap_r),
    .res_o  (step_res)
  );

  cds_report_unit u_report (
    .date_i (rep_date),
    .leap_i (rep_leap),
    .rep_o  (rep)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    wrk_nxt        = wrk_r;
    leap_nxt       = leap_r;
    err_nxt        = err_r;
    cur_nxt        = cur_r;
    cur_leap_nxt   = cur_leap_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_date_nxt   = out_date_r;
    out_leap_nxt   = out_leap_r;
    out_rep_nxt    = out_rep_r;
    out_status_nxt = out_status_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_op;
          cnt_nxt  = cnt_sat;
          wrk_nxt  = cur_r;
          leap_nxt = cur_leap_r;
          err_nxt  = 1'b0;
          case (in_op)
            cds_pkg::OP_LOAD: begin
              if (in_load_year > cds_pkg::YEAR_W'(YEAR_MAX)) begin
                err_nxt   = 1'b1;
                state_nxt = ST_REPORT;
              end else begin
                wrk_nxt.year  = in_load_year;
                wrk_nxt.month = in_load_month;
                wrk_nxt.day   = in_load_day;
                state_nxt     = ST_LEAP;
              end
            end
            cds_pkg::OP_DAY_INC, cds_pkg::OP_DAY_DEC,
            cds_pkg::OP_MON_INC, cds_pkg::OP_MON_DEC: begin
              state_nxt = (cnt_sat == '0) ? ST_REPORT : ST_STEP;
            end
            cds_pkg::OP_YEAR_INC: begin
              if (yinc_err) begin
                err_nxt   = 1'b1;
                state_nxt = ST_REPORT;
              end else begin
                wrk_nxt.year = ysum[cds_pkg::YEAR_W-1:0];
                state_nxt    = ST_LEAP;
              end
            end
            cds_pkg::OP_YEAR_DEC: begin
              if (ydec_err) begin
                err_nxt   = 1'b1;
                state_nxt = ST_REPORT;
              end else begin
                wrk_nxt.year = ydiff;
                state_nxt    = ST_LEAP;
              end
            end
            default: begin
              state_nxt = ST_REPORT;
            end
          endcase
        end
      end
      ST_STEP: begin
        if (step_res.err) begin
          err_nxt   = 1'b1;
          state_nxt = ST_REPORT;
        end else begin
          wrk_nxt = step_res.date;
          cnt_nxt = cnt_r - 10'd1;
          if (step_res.year_chg) begin
            state_nxt = ST_LEAP;
          end else if (cnt_r == 10'd1) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_LEAP: begin
        leap_nxt = cds_pkg::is_leap(wrk_r.year);
        if ((op_r == cds_pkg::OP_YEAR_INC) || (op_r == cds_pkg::OP_YEAR_DEC)) begin
          state_nxt = ST_YFIX;
        end else if (multi_op && (cnt_r != '0)) begin
          state_nxt = ST_STEP;
        end else begin
          state_nxt = ST_REPORT;
        end
      end
      ST_YFIX: begin
        if ((wrk_r.month == cds_pkg::MON_FEB) && (wrk_r.day == cds_pkg::DAY_29) && !leap_r) begin
          wrk_nxt.day = cds_pkg::DAY_28;
        end
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_date_nxt   = rep_date;
          out_leap_nxt   = rep_leap;
          out_rep_nxt    = rep;
          out_status_nxt = err_r;
          if (!err_r) begin
            cur_nxt      = wrk_r;
            cur_leap_nxt = leap_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_r.year  <= '0;
      cur_r.month <= cds_pkg::MON_JAN;
      cur_r.day   <= cds_pkg::DAY_FIRST;
      cur_leap_r  <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      cur_leap_r  <= cur_leap_nxt;
    end
    op_r         <= op_nxt;
    cnt_r        <= cnt_nxt;
    wrk_r        <= wrk_nxt;
    leap_r       <= leap_nxt;
    err_r        <= err_nxt;
    out_date_r   <= out_date_nxt;
    out_leap_r   <= out_leap_nxt;
    out_rep_r    <= out_rep_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_year_out     = out_date_r.year;
  assign out_month_out    = out_date_r.month;
  assign out_day_out      = out_date_r.day;
  assign out_leap_year    = out_leap_r;
  assign out_date_valid   = out_rep_r.date_valid;
  assign out_day_of_year  = out_rep_r.doy;
  assign out_week_of_year = out_rep_r.woy;
  assign out_status       = out_status_r;

`ifndef SYNTH
  // a held result always shows the committed date
  a_out_matches_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year_out == cur_r.year) && (out_month_out == cur_r.month) &&
                  (out_day_out == cur_r.day))
    else $error("held result differs from committed date");

  a_year_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r.year <= cds_pkg::YEAR_W'(YEAR_MAX))
    else $error("committed year out of range");

  a_cur_leap: assert property (@(posedge clk) disable iff (!rst_n)
    cur_leap_r == cds_pkg::is_leap(cur_r.year))
    else $error("committed leap flag stale");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after transfer");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (cnt_r != '0))
    else $error("step with zero count left");
`endif

endmodule

### test/tb.sv
// tb: self-checking bench for calendar_date_stepper, a directed table then random items
// checked against a calendar model kept in the bench; depends on cds_pkg and the block
module tb;

  localparam int LAST_YEAR    = 9999;
  localparam int ITEM_TOTAL   = 1650;
  localparam int SCRIPT_ROWS  = 25;
  localparam int STALL_LIMIT  = 6000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [cds_pkg::YEAR_W-1:0]  year;
    logic [cds_pkg::MONTH_W-1:0] month;
    logic [cds_pkg::DAY_W-1:0]   day;
    logic                        leap;
    logic                        valid;
    logic [cds_pkg::DOY_W-1:0]   doy;
    logic [cds_pkg::WOY_W-1:0]   woy;
    logic                        status;
  } date_report_t;

  typedef struct {
    cds_pkg::op_t op;
    int  cnt, ly, lm, ld;
    bit  typed;
    int  y, m, d, lp, v, doy, woy, st;
  } script_row_t;

  // op, count, load y/m/d, typed, then year month day leap valid doy week status
  script_row_t date_script [SCRIPT_ROWS] = '{
    '{cds_pkg::OP_QUERY,       0,     0,  0,  0, 1,    0,  1,  1, 1, 1,   1,  1, 0},
    '{cds_pkg::OP_DAY_DEC,     1,     0,  0,  0, 1,    0,  1,  1, 1, 1,   1,  1, 1},
    '{cds_pkg::OP_MON_DEC,     1,     0,  0,  0, 1,    0,  1,  1, 1, 1,   1,  1, 1},
    '{cds_pkg::OP_LOAD,        0, 16383, 15, 31, 1,    0,  1,  1, 1, 1,   1,  1, 1},
    '{cds_pkg::OP_LOAD,     1023,  9999, 12, 31, 1, 9999, 12, 31, 0, 1, 365, 53, 0},
    '{cds_pkg::OP_DAY_INC,     1,     0,  0,  0, 1, 9999, 12, 31, 0, 1, 365, 53, 1},
    '{cds_pkg::OP_MON_INC,     1,     0,  0,  0, 1, 9999, 12, 31, 0, 1, 365, 53, 1},
    '{cds_pkg::OP_YEAR_INC,    1,     0,  0,  0, 1, 9999, 12, 31, 0, 1, 365, 53, 1},
    '{cds_pkg::OP_DAY_DEC,  1023,     0,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_LOAD,        0,  2000,  2, 29, 1, 2000,  2, 29, 1, 1,  60,  9, 0},
    '{cds_pkg::OP_YEAR_INC,    1,     0,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_LOAD,        0,  1900,  2, 29, 1, 1900,  2, 29, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_YEAR_INC,    0,     0,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_LOAD,        0,     0,  0,  0, 1,    0,  0,  0, 1, 0,   0,  0, 0},
    '{cds_pkg::OP_LOAD,        0,     5,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_DAY_DEC,     1,     0,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_LOAD,        0,  2023, 15, 31, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_DAY_INC,     1,     0,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_LOAD,        0,  2023, 13,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_MON_DEC,     1,     0,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_LOAD,        0,  2023,  1, 31, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_MON_INC,  1023,     0,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_MON_DEC,  1023,     0,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_YEAR_DEC, 1023,     0,  0,  0, 0,    0,  0,  0, 0, 0,   0,  0, 0},
    '{cds_pkg::OP_QUERY,    1023, 16383, 15, 31, 0,    0,  0,  0, 0, 0,   0,  0, 0}
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [cds_pkg::OP_W-1:0]     in_operation = '0;
  logic [cds_pkg::CNT_W-1:0]    in_step_count = '0;
  logic [cds_pkg::YEAR_W-1:0]   in_load_year = '0;
  logic [cds_pkg::MONTH_W-1:0]  in_load_month = '0;
  logic [cds_pkg::DAY_W-1:0]    in_load_day = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [cds_pkg::YEAR_W-1:0]   out_year_out;
  logic [cds_pkg::MONTH_W-1:0]  out_month_out;
  logic [cds_pkg::DAY_W-1:0]    out_day_out;
  logic                         out_leap_year;
  logic                         out_date_valid;
  logic [cds_pkg::DOY_W-1:0]    out_day_of_year;
  logic [cds_pkg::WOY_W-1:0]    out_week_of_year;
  logic                         out_status;

  date_report_t pending_reports[$];
  int unsigned  cal_year = 0;
  int unsigned  cal_month = 1;
  int unsigned  cal_day = 1;
  int           mismatches = 0;
  int           reports_checked = 0;
  int           refusals_seen = 0;
  int           quiet_cycles = 0;
  bit           calm = 1'b0;

  calendar_date_stepper DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_step_count    (in_step_count),
    .in_load_year     (in_load_year),
    .in_load_month    (in_load_month),
    .in_load_day      (in_load_day),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_leap_year    (out_leap_year),
    .out_date_valid   (out_date_valid),
    .out_day_of_year  (out_day_of_year),
    .out_week_of_year (out_week_of_year),
    .out_status       (out_status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit gregorian_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      2: len = gregorian_leap(y) ? 29 : 28;
      1, 3, 5, 7, 8, 10, 12: len = 31;
      default: len = 30;
    endcase
    return len;
  endfunction

  // applies one transfer to the held date and returns the report it produces
  function automatic date_report_t step_calendar(cds_pkg::op_t op, int unsigned cnt,
                                                 int unsigned ly, int unsigned lm,
                                                 int unsigned ld);
    int unsigned  y, m, d, n, doy;
    bit           refused, ok;
    date_report_t rep;
    y = cal_year;
    m = cal_month;
    d = cal_day;
    refused = 1'b0;
    case (op)
      cds_pkg::OP_LOAD: begin
        if (ly > LAST_YEAR) refused = 1'b1;
        else begin
          y = ly;
          m = lm;
          d = ld;
        end
      end
      cds_pkg::OP_DAY_INC: begin
        for (n = 0; n < cnt && !refused; n++) begin
          if (d >= days_in_month(y, m)) begin
            d = 1;
            if (m >= 12) begin
              if (y >= LAST_YEAR) refused = 1'b1;
              else begin
                y++;
                m = 1;
              end
            end else m++;
          end else d++;
        end
      end
      cds_pkg::OP_DAY_DEC: begin
        for (n = 0; n < cnt && !refused; n++) begin
          if (d > 1) d--;
          else if (m > 1) begin
            m--;
            d = days_in_month(y, m);
          end else if (y == 0) refused = 1'b1;
          else begin
            y--;
            m = 12;
            d = 31;
          end
        end
      end
      cds_pkg::OP_MON_INC: begin
        for (n = 0; n < cnt && !refused; n++) begin
          if (m >= 12) begin
            if (y >= LAST_YEAR) refused = 1'b1;
            else begin
              y++;
              m = 1;
            end
          end else m++;
          if (d > days_in_month(y, m)) d = days_in_month(y, m);
        end
      end
      cds_pkg::OP_MON_DEC: begin
        for (n = 0; n < cnt && !refused; n++) begin
          if (m > 1) m--;
          else if (y == 0) refused = 1'b1;
          else begin
            y--;
            m = 12;
          end
          if (d > days_in_month(y, m)) d = days_in_month(y, m);
        end
      end
      cds_pkg::OP_YEAR_INC, cds_pkg::OP_YEAR_DEC: begin
        if (op == cds_pkg::OP_YEAR_INC) begin
          if (cnt > LAST_YEAR - y) refused = 1'b1;
          else y = y + cnt;
        end else begin
          if (cnt > y) refused = 1'b1;
          else y = y - cnt;
        end
        if (m == 2 && d == 29 && !gregorian_leap(y)) d = 28;
      end
      default: ;
    endcase
    if (!refused) begin
      cal_year = y;
      cal_month = m;
      cal_day = d;
    end
    ok = cal_month >= 1 && cal_month <= 12 && cal_day >= 1 &&
         cal_day <= days_in_month(cal_year, cal_month);
    doy = 0;
    if (ok) begin
      for (n = 1; n < cal_month; n++) doy += days_in_month(cal_year, n);
      doy += cal_day;
    end
    rep.year   = cds_pkg::YEAR_W'(cal_year);
    rep.month  = cds_pkg::MONTH_W'(cal_month);
    rep.day    = cds_pkg::DAY_W'(cal_day);
    rep.leap   = gregorian_leap(cal_year);
    rep.valid  = ok;
    rep.doy    = cds_pkg::DOY_W'(doy);
    rep.woy    = ok ? cds_pkg::WOY_W'((doy - 1) / 7 + 1) : '0;
    rep.status = refused;
    return rep;
  endfunction

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    date_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with no expected result, actual %0d-%0d-%0d",
                 $time, out_year_out, out_month_out, out_day_out);
      end else begin
        want = pending_reports.pop_front();
        compare_field("year_out", want.year, out_year_out);
        compare_field("month_out", want.month, out_month_out);
        compare_field("day_out", want.day, out_day_out);
        compare_field("leap_year", want.leap, out_leap_year);
        compare_field("date_valid", want.valid, out_date_valid);
        compare_field("day_of_year", want.doy, out_day_of_year);
        compare_field("week_of_year", want.woy, out_week_of_year);
        compare_field("status", want.status, out_status);
        reports_checked++;
        if (want.status) refusals_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results still expected",
               $time, STALL_LIMIT, pending_reports.size());
      $display("calendar_date_stepper verification failed");
      $finish;
    end
  end

  initial begin
    cds_pkg::op_t op;
    int unsigned  cnt, ly, lm, ld, pick;
    date_report_t rep;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < ITEM_TOTAL; k++) begin
      calm = (k >= 700 && k < 1000);
      if (k < SCRIPT_ROWS) begin
        op  = date_script[k].op;
        cnt = date_script[k].cnt;
        ly  = date_script[k].ly;
        lm  = date_script[k].lm;
        ld  = date_script[k].ld;
      end else begin
        ly  = $urandom_range(16383);
        lm  = $urandom_range(15);
        ld  = $urandom_range(31);
        pick = $urandom_range(99);
        if (pick < 8) cnt = $urandom_range(1023);
        else if (pick < 25) cnt = $urandom_range(400);
        else cnt = $urandom_range(40);
        if ($urandom_range(99) < 18) begin
          op = cds_pkg::OP_LOAD;
          pick = $urandom_range(99);
          if (pick < 15) ly = $urandom_range(3);
          else if (pick < 30) ly = $urandom_range(9999, 9996);
          else if (pick < 40) ly = 100 * $urandom_range(99);
          else if (pick < 88) ly = $urandom_range(9999);
          if ($urandom_range(99) < 88) lm = $urandom_range(12, 1);
          pick = $urandom_range(99);
          if (pick < 30) ld = days_in_month(ly, lm) - $urandom_range(1);
          else if (pick < 85) ld = $urandom_range(days_in_month(ly, lm), 1);
        end else begin
          op = cds_pkg::op_t'($urandom_range(7, 1));
        end
      end
      while (!calm && $urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_operation  <= op;
      in_step_count <= cds_pkg::CNT_W'(cnt);
      in_load_year  <= cds_pkg::YEAR_W'(ly);
      in_load_month <= cds_pkg::MONTH_W'(lm);
      in_load_day   <= cds_pkg::DAY_W'(ld);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      rep = step_calendar(op, cnt, ly, lm, ld);
      if (k < SCRIPT_ROWS && date_script[k].typed) begin
        rep.year   = cds_pkg::YEAR_W'(date_script[k].y);
        rep.month  = cds_pkg::MONTH_W'(date_script[k].m);
        rep.day    = cds_pkg::DAY_W'(date_script[k].d);
        rep.leap   = date_script[k].lp != 0;
        rep.valid  = date_script[k].v != 0;
        rep.doy    = cds_pkg::DOY_W'(date_script[k].doy);
        rep.woy    = cds_pkg::WOY_W'(date_script[k].woy);
        rep.status = date_script[k].st != 0;
      end
      pending_reports.push_back(rep);
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items driven (%0d from the directed table), %0d results checked",
             ITEM_TOTAL, SCRIPT_ROWS, reports_checked);
    $display("%0d steps refused at the year limits, %0d field mismatches",
             refusals_seen, mismatches);
    if (mismatches == 0) begin
      $display("calendar_date_stepper verification clean");
    end else begin
      $display("calendar_date_stepper verification failed");
    end
    $finish;
  end

endmodule

### calendar_date_stepper.f
src/cds_pkg.sv
src/cds_step_unit.sv
src/cds_report_unit.sv
src/calendar_date_stepper.sv
test/tb.sv
